>>> rtl/rlpc_pkg.sv
// Shared types and constants of the run-length pattern counter.
`default_nettype none

package rlpc_pkg;

	localparam int RUN_W   = 20;
	localparam int FOUND_W = 40;
	localparam int TOTAL_W = 48;

	localparam logic [FOUND_W-1:0] FOUND_MAX = {FOUND_W{1'b1}};
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

	localparam logic [1:0] OP_PATTERN = 2'd0;
	localparam logic [1:0] OP_TEXT    = 2'd1;
	localparam logic [1:0] OP_FLUSH   = 2'd2;
	localparam logic [1:0] OP_CLEAR   = 2'd3;

	localparam logic [1:0] STATUS_OK         = 2'd0;
	localparam logic [1:0] STATUS_TOO_LONG   = 2'd1;
	localparam logic [1:0] STATUS_NO_PATTERN = 2'd2;

	typedef struct packed {
		logic [1:0]       operation;
		logic [7:0]       symbol;
		logic [RUN_W-1:0] run_length;
	} item_t;

	typedef struct packed {
		logic [TOTAL_W-1:0] occurrence_total;
		logic [FOUND_W-1:0] found_now;
		logic [1:0]         status;
	} result_t;

	typedef struct packed {
		logic               clear;
		logic [FOUND_W-1:0] found;
		logic [1:0]         status;
	} step_t;

endpackage

`default_nettype wire

>>> rtl/run_length_pattern_counter.sv
// Top level of the run-length pattern counter: handshake pipeline and stage wiring.
//
// Takes one word per cycle on item while item_ready is high, and returns one result
// word per item on result. From accept to result valid an item passes three
// registers: an input register, the window-compare stage, and the total/result
// register. The window-compare stage compares MAX_PATTERN_RUNS window lanes
// against the pattern in parallel. Each stage holds its word when the next
// one is full, so an item is still accepted while a finished result waits to be taken.
`default_nettype none

module run_length_pattern_counter #(
	parameter int MAX_PATTERN_RUNS = 16,
	parameter int LENGTH_BITS      = 40
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_ready,
	input  wire rlpc_pkg::item_t   item,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output rlpc_pkg::result_t      result
);
	import rlpc_pkg::*;

	item_t item_s1;
	step_t step_s2;
	logic  valid_s1_q;
	logic  valid_s2_q;
	logic  out_free;
	logic  s2_free;
	logic  take_s1;
	logic  take_s2;

	assign out_free   = !result_valid || result_ready;
	assign s2_free    = !valid_s2_q || out_free;
	assign item_ready = !valid_s1_q || s2_free;
	assign take_s1    = valid_s1_q && s2_free;
	assign take_s2    = valid_s2_q && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q   <= 1'b0;
			valid_s2_q   <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (item_valid && item_ready) begin
				valid_s1_q <= 1'b1;
			end else if (take_s1) begin
				valid_s1_q <= 1'b0;
			end
			if (take_s1) begin
				valid_s2_q <= 1'b1;
			end else if (take_s2) begin
				valid_s2_q <= 1'b0;
			end
			if (take_s2) begin
				result_valid <= 1'b1;
			end else if (result_ready) begin
				result_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	rlpc_match #(
		.MAX_PATTERN_RUNS(MAX_PATTERN_RUNS),
		.LENGTH_BITS(LENGTH_BITS)
	) u_match (
		.clk(clk),
		.arst_n(arst_n),
		.take(take_s1),
		.item_s1(item_s1),
		.step_s2(step_s2)
	);

	rlpc_accum u_accum (
		.clk(clk),
		.arst_n(arst_n),
		.take(take_s2),
		.step_s2(step_s2),
		.result_q(result)
	);

endmodule

`default_nettype wire

>>> rtl/rlpc_match.sv
// Pattern store, open text run, run window and parallel window compare.
`default_nettype none

module rlpc_match #(
	parameter int MAX_PATTERN_RUNS = 16,
	parameter int LENGTH_BITS      = 40
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           take,
	input  wire rlpc_pkg::item_t item_s1,
	output rlpc_pkg::step_t     step_s2
);
	import rlpc_pkg::*;

	localparam int CNT_W = $clog2(MAX_PATTERN_RUNS + 1);
	localparam int EXT_W = (LENGTH_BITS + 1 > FOUND_W + 1) ? LENGTH_BITS + 1 : FOUND_W + 1;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PATTERN_RUNS);
	localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

	function automatic logic [LENGTH_BITS-1:0] sat_len(
		input logic [LENGTH_BITS-1:0] a,
		input logic [LENGTH_BITS-1:0] b
	);
		logic [LENGTH_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[LENGTH_BITS] ? LEN_MAX : s[LENGTH_BITS-1:0];
	endfunction

	logic [7:0]             pat_sym_q [MAX_PATTERN_RUNS];
	logic [LENGTH_BITS-1:0] pat_len_q [MAX_PATTERN_RUNS];
	logic [CNT_W-1:0]       pat_cnt_q;
	logic [7:0]             win_sym_q [MAX_PATTERN_RUNS];
	logic [LENGTH_BITS-1:0] win_len_q [MAX_PATTERN_RUNS];
	logic [CNT_W-1:0]       fill_q;
	logic [7:0]             pend_sym_q;
	logic [LENGTH_BITS-1:0] pend_len_q;
	logic                   pend_valid_q;

	logic [1:0]             op;
	logic [7:0]             sym;
	logic [LENGTH_BITS-1:0] len;
	logic                   len_zero;
	logic                   pat_merge;
	logic                   pat_full;
	logic                   pend_merge;
	logic                   close_run;
	logic [CNT_W-1:0]       fill_next;
	logic [7:0]             nw_sym [MAX_PATTERN_RUNS];
	logic [LENGTH_BITS-1:0] nw_len [MAX_PATTERN_RUNS];
	logic [MAX_PATTERN_RUNS-1:0] lane_ok;
	logic                   multi_hit;
	logic                   single_hit;
	logic [EXT_W-1:0]       single_diff;
	logic [FOUND_W-1:0]     found;
	logic [1:0]             status;

	assign op       = item_s1.operation;
	assign sym      = item_s1.symbol;
	assign len      = LENGTH_BITS'(item_s1.run_length);
	assign len_zero = (item_s1.run_length == '0);

	assign pat_merge  = (pat_cnt_q != '0) && (pat_sym_q[0] == sym);
	assign pat_full   = (pat_cnt_q == CNT_MAX);
	assign pend_merge = pend_valid_q && (pend_sym_q == sym);
	assign fill_next  = (fill_q == CNT_MAX) ? fill_q : fill_q + CNT_W'(1);

	always_comb begin
		close_run = 1'b0;
		status    = STATUS_OK;
		unique case (op)
			OP_PATTERN: begin
				if (!len_zero && !pat_merge && pat_full) begin
					status = STATUS_TOO_LONG;
				end
			end
			OP_TEXT: begin
				if (pat_cnt_q == '0) begin
					status = STATUS_NO_PATTERN;
				end else if (!len_zero && pend_valid_q && !pend_merge) begin
					close_run = 1'b1;
				end
			end
			OP_FLUSH: begin
				close_run = pend_valid_q;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		nw_sym[0] = pend_sym_q;
		nw_len[0] = pend_len_q;
		for (int a = 1; a < MAX_PATTERN_RUNS; a++) begin
			nw_sym[a] = win_sym_q[a-1];
			nw_len[a] = win_len_q[a-1];
		end
		for (int a = 0; a < MAX_PATTERN_RUNS; a++) begin
			if (CNT_W'(a) >= pat_cnt_q) begin
				lane_ok[a] = 1'b1;
			end else if (a == 0 || CNT_W'(a) == pat_cnt_q - CNT_W'(1)) begin
				lane_ok[a] = (nw_sym[a] == pat_sym_q[a]) && (nw_len[a] >= pat_len_q[a]);
			end else begin
				lane_ok[a] = (nw_sym[a] == pat_sym_q[a]) && (nw_len[a] == pat_len_q[a]);
			end
		end
	end

	assign multi_hit   = (pat_cnt_q >= CNT_W'(2)) && (fill_next >= pat_cnt_q) && (&lane_ok);
	assign single_hit  = (pat_cnt_q == CNT_W'(1)) && lane_ok[0];
	assign single_diff = EXT_W'(pend_len_q) - EXT_W'(pat_len_q[0]) + EXT_W'(1);

	always_comb begin
		found = '0;
		if (close_run) begin
			if (single_hit) begin
				found = (single_diff > EXT_W'(FOUND_MAX)) ? FOUND_MAX : FOUND_W'(single_diff);
			end else if (multi_hit) begin
				found = FOUND_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_cnt_q    <= '0;
			fill_q       <= '0;
			pend_valid_q <= 1'b0;
		end else if (take) begin
			unique case (op)
				OP_PATTERN: begin
					if (!len_zero && !pat_merge && !pat_full) begin
						pat_cnt_q <= pat_cnt_q + CNT_W'(1);
					end
				end
				OP_TEXT: begin
					if (pat_cnt_q != '0 && !len_zero) begin
						pend_valid_q <= 1'b1;
						if (close_run) begin
							fill_q <= fill_next;
						end
					end
				end
				OP_FLUSH: begin
					pend_valid_q <= 1'b0;
					fill_q       <= '0;
				end
				default: begin
					pat_cnt_q    <= '0;
					fill_q       <= '0;
					pend_valid_q <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			step_s2 <= '{clear: (op == OP_CLEAR), found: found, status: status};
			if (op == OP_PATTERN && !len_zero) begin
				if (pat_merge) begin
					pat_len_q[0] <= sat_len(pat_len_q[0], len);
				end else if (!pat_full) begin
					for (int k = 1; k < MAX_PATTERN_RUNS; k++) begin
						pat_sym_q[k] <= pat_sym_q[k-1];
						pat_len_q[k] <= pat_len_q[k-1];
					end
					pat_sym_q[0] <= sym;
					pat_len_q[0] <= len;
				end
			end
			if (close_run) begin
				for (int k = 0; k < MAX_PATTERN_RUNS; k++) begin
					win_sym_q[k] <= nw_sym[k];
					win_len_q[k] <= nw_len[k];
				end
			end
			if (op == OP_TEXT && pat_cnt_q != '0 && !len_zero) begin
				if (pend_merge) begin
					pend_len_q <= sat_len(pend_len_q, len);
				end else begin
					pend_sym_q <= sym;
					pend_len_q <= len;
				end
			end
		end
	end

	a_pend_needs_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> pat_cnt_q != '0)
		else $error("open text run without a pattern");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pat_cnt_q <= CNT_MAX && fill_q <= CNT_MAX)
		else $error("pattern count or window fill beyond depth");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		take && op == OP_CLEAR |=> !pend_valid_q && pat_cnt_q == '0 && fill_q == '0)
		else $error("clear left state behind");

	a_found_on_close: assert property (@(posedge clk) disable iff (!arst_n)
		take && !close_run |=> step_s2.found == '0)
		else $error("count reported without a closed run");

endmodule

`default_nettype wire

>>> rtl/rlpc_accum.sv
// Saturating occurrence total and result register.
`default_nettype none

module rlpc_accum (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            take,
	input  wire rlpc_pkg::step_t step_s2,
	output rlpc_pkg::result_t    result_q
);
	import rlpc_pkg::*;

	logic [TOTAL_W-1:0] total_q;
	logic [TOTAL_W:0]   sum;
	logic [TOTAL_W-1:0] total_next;

	assign sum = {1'b0, total_q} + (TOTAL_W + 1)'(step_s2.found);

	always_comb begin
		if (step_s2.clear) begin
			total_next = '0;
		end else if (sum > (TOTAL_W + 1)'(TOTAL_MAX)) begin
			total_next = TOTAL_MAX;
		end else begin
			total_next = sum[TOTAL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (take) begin
			total_q <= total_next;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			result_q <= '{occurrence_total: total_next, found_now: step_s2.found,
				status: step_s2.status};
		end
	end

endmodule

`default_nettype wire
